>>> sv/dof_pkg.sv
// ----------------------------------------------------------------------------
// dof_pkg
// Shared types, operation codes and helper functions of the density filter.
// ----------------------------------------------------------------------------
package dof_pkg;

  localparam int ValW = 32;
  localparam int SumW = 36;
  localparam int CntW = 5;
  localparam int WinW = 7;
  localparam int KeepW = 17;

  // Operation codes broadcast to the cells.
  localparam logic [2:0] OP_HOLD  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_PREP  = 3'd2;
  localparam logic [2:0] OP_SCORE = 3'd3;
  localparam logic [2:0] OP_SHIFT = 3'd4;
  localparam logic [2:0] OP_CLEAR = 3'd5;
  localparam logic [2:0] OP_INS   = 3'd6;

  typedef struct packed {
    logic [ValW-1:0] val;
    logic            vld;
    logic [SumW-1:0] sum;
    logic [CntW-1:0] cnt;
  } point_t;

  typedef struct packed {
    logic [2:0]      op;
    logic [ValW-1:0] x;
  } sort_ctl_t;

  // Density class: 0 no neighbours, 2 zero distance, 1 ordinary.
  function automatic logic [1:0] dens_class(point_t p);
    logic [1:0] c;
    if (p.cnt == '0) c = 2'd0;
    else if (p.sum == '0) c = 2'd2;
    else c = 2'd1;
    return c;
  endfunction

  // True when a is strictly denser than b (cross-multiplied compare).
  function automatic logic denser(point_t a, point_t b);
    logic [1:0] ca;
    logic [1:0] cb;
    logic [SumW+CntW-1:0] pa;
    logic [SumW+CntW-1:0] pb;
    logic r;
    ca = dens_class(a);
    cb = dens_class(b);
    pa = (SumW+CntW)'(a.cnt) * (SumW+CntW)'(b.sum);
    pb = (SumW+CntW)'(b.cnt) * (SumW+CntW)'(a.sum);
    if (ca != cb) r = (ca > cb);
    else if (ca != 2'd1) r = 1'b0;
    else r = (pa > pb);
    return r;
  endfunction

  // Floor of the square root of a count of at most 64.
  function automatic logic [WinW-1:0] isqrt(logic [WinW-1:0] n);
    logic [WinW-1:0] r;
    r = '0;
    for (int i = 1; i <= 8; i++) begin
      if (14'(i * i) <= 14'(n)) r = WinW'(i);
    end
    return r;
  endfunction

endpackage

>>> sv/dof_sort_cell.sv
// ----------------------------------------------------------------------------
// dof_sort_cell
// One cell of the ascending insertion chain; also scores its own point by
// accumulating distances to values travelling past in both directions.
// ----------------------------------------------------------------------------
module dof_sort_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dof_pkg::sort_ctl_t            ctl,
  input  dof_pkg::point_t               pt_l,
  input  logic                          ins_l,
  input  logic [dof_pkg::ValW-1:0]      trr_l,
  input  logic                          trr_v_l,
  input  dof_pkg::point_t               pt_r,
  input  logic [dof_pkg::ValW-1:0]      trl_r,
  input  logic                          trl_v_r,
  output dof_pkg::point_t               pt,
  output logic                          ins,
  output logic [dof_pkg::ValW-1:0]      trl,
  output logic                          trl_v,
  output logic [dof_pkg::ValW-1:0]      trr,
  output logic                          trr_v
);
  import dof_pkg::*;

  point_t          pt_r_q, pt_nxt;
  logic [ValW-1:0] trl_r_q, trl_nxt, trr_r_q, trr_nxt;
  logic            trlv_r, trlv_nxt, trrv_r, trrv_nxt;
  logic [ValW-1:0] dl, dr;

  assign ins = !pt_r_q.vld || (pt_r_q.val > ctl.x);
  assign dl  = (trl_r >= pt_r_q.val) ? trl_r - pt_r_q.val : pt_r_q.val - trl_r;
  assign dr  = (trr_l >= pt_r_q.val) ? trr_l - pt_r_q.val : pt_r_q.val - trr_l;

  always_comb begin
    pt_nxt   = pt_r_q;
    trl_nxt  = trl_r_q;
    trr_nxt  = trr_r_q;
    trlv_nxt = trlv_r;
    trrv_nxt = trrv_r;
    case (ctl.op)
      OP_LOAD: begin
        if (ins) begin
          if (ins_l) begin
            pt_nxt.val = pt_l.val;
            pt_nxt.vld = pt_l.vld;
          end else begin
            pt_nxt.val = ctl.x;
            pt_nxt.vld = 1'b1;
          end
        end
      end
      OP_PREP: begin
        trl_nxt    = pt_r_q.val;
        trr_nxt    = pt_r_q.val;
        trlv_nxt   = pt_r_q.vld;
        trrv_nxt   = pt_r_q.vld;
        pt_nxt.sum = '0;
        pt_nxt.cnt = '0;
      end
      OP_SCORE: begin
        trl_nxt  = trl_r;
        trlv_nxt = trl_v_r;
        trr_nxt  = trr_l;
        trrv_nxt = trr_v_l;
        pt_nxt.sum = pt_r_q.sum + (trl_v_r ? SumW'(dl) : '0)
                                + (trr_v_l ? SumW'(dr) : '0);
        pt_nxt.cnt = pt_r_q.cnt + CntW'(trl_v_r) + CntW'(trr_v_l);
      end
      OP_SHIFT: pt_nxt = pt_r;
      OP_CLEAR: pt_nxt.vld = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r_q.vld <= 1'b0;
    end else begin
      pt_r_q.vld <= pt_nxt.vld;
    end
    pt_r_q.val <= pt_nxt.val;
    pt_r_q.sum <= pt_nxt.sum;
    pt_r_q.cnt <= pt_nxt.cnt;
    trl_r_q    <= trl_nxt;
    trr_r_q    <= trr_nxt;
    trlv_r     <= trlv_nxt;
    trrv_r     <= trrv_nxt;
  end

  assign pt    = pt_r_q;
  assign trl   = trl_r_q;
  assign trr   = trr_r_q;
  assign trl_v = trlv_r;
  assign trr_v = trrv_r;

endmodule

>>> sv/dof_rank_cell.sv
// ----------------------------------------------------------------------------
// dof_rank_cell
// One cell of the density chain, kept in order of falling density with
// equal densities in arrival order.
// ----------------------------------------------------------------------------
module dof_rank_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [2:0]      op,
  input  dof_pkg::point_t y,
  input  dof_pkg::point_t pt_l,
  input  logic            ins_l,
  input  dof_pkg::point_t pt_r,
  output dof_pkg::point_t pt,
  output logic            ins
);
  import dof_pkg::*;

  point_t pt_q, pt_nxt;

  assign ins = !pt_q.vld || denser(y, pt_q);

  always_comb begin
    pt_nxt = pt_q;
    case (op)
      OP_INS: begin
        if (ins) pt_nxt = ins_l ? pt_l : y;
      end
      OP_SHIFT: pt_nxt = pt_r;
      OP_CLEAR: pt_nxt.vld = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_q.vld <= 1'b0;
    end else begin
      pt_q.vld <= pt_nxt.vld;
    end
    pt_q.val <= pt_nxt.val;
    pt_q.sum <= pt_nxt.sum;
    pt_q.cnt <= pt_nxt.cnt;
  end

  assign pt = pt_q;

endmodule

>>> sv/density_outlier_filter_unit.sv
// ----------------------------------------------------------------------------
// density_outlier_filter_unit
// Local density outlier rejection over a set of unsigned samples.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake        Content
//  in_      in         valid / stall    sample_value, is_final
//  out_     out        valid / stall    kept_value, final_result, none_kept,
//                                       overflowed
//  cfg_     in         valid / ready    keep_fraction write data
//
// Samples load one per cycle into an ascending insertion chain of cells.
// After the final request the block passes through a setup state, a scoring
// state in which values travel through the chain to the W neighbours on each
// side of every cell (W at most 8 for 64 samples), and a drain state moving
// the scored points into the density chain until the sort chain is empty.
// Results then leave the density chain head one per cycle unless stalled.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result holds its payload; input is stalled outside loading.
module density_outlier_filter_unit #(
  parameter int MAX_SAMPLES = 64,
  parameter int MIN_WINDOW  = 3,
  parameter int MAX_WINDOW  = 100
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dof_pkg::ValW-1:0]    in_sample_value,
  input  logic                        in_is_final,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dof_pkg::ValW-1:0]    out_kept_value,
  output logic                        out_final_result,
  output logic                        out_none_kept,
  output logic                        out_overflowed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dof_pkg::KeepW-1:0]   cfg_keep_fraction
);
  import dof_pkg::*;

  localparam int N = MAX_SAMPLES;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [KeepW-1:0] KeepReset = 17'd55706;

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_SCORE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [KeepW-1:0] keep_r, keep_nxt;
  logic [WinW-1:0]  win_r, win_nxt;
  logic [WinW-1:0]  step_r, step_nxt;
  logic [CW-1:0]    left_r, left_nxt;
  logic             none_r, none_nxt;

  logic in_acc, out_acc;
  logic [WinW-1:0] root, win_c;
  logic [KeepW+CW:0] kprod;
  logic [CW-1:0] kval;

  sort_ctl_t sctl;
  logic [2:0] rop;

  point_t          spt [N];
  logic            sins [N];
  logic [ValW-1:0] strl [N];
  logic            strlv [N];
  logic [ValW-1:0] strr [N];
  logic            strrv [N];
  point_t          rpt [N];
  logic            rins [N];

  point_t nil_pt;
  assign nil_pt = '0;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall  = (state_r != ST_LOAD);
  assign cfg_ready = 1'b1;

  // Window from the loaded count, clamped to the configured range.
  assign root  = isqrt(WinW'(count_r));
  assign win_c = (root < WinW'(MIN_WINDOW)) ? WinW'(MIN_WINDOW) :
                 (root > WinW'(MAX_WINDOW)) ? WinW'(MAX_WINDOW) : root;
  // Kept count with a half rounding up, saturated at the loaded count.
  assign kprod = ((KeepW+CW+1)'(keep_r) * (KeepW+CW+1)'(count_r))
                 + (KeepW+CW+1)'(32768);
  assign kval  = ((kprod >> 16) > (KeepW+CW+1)'(count_r)) ? count_r
                 : CW'(kprod >> 16);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    keep_nxt  = keep_r;
    win_nxt   = win_r;
    step_nxt  = step_r;
    left_nxt  = left_r;
    none_nxt  = none_r;
    sctl.op   = OP_HOLD;
    sctl.x    = in_sample_value;
    rop       = OP_HOLD;
    if (cfg_valid && cfg_ready) keep_nxt = cfg_keep_fraction;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_SAMPLES)) begin
            sctl.op   = OP_LOAD;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_is_final) state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        sctl.op   = OP_PREP;
        rop       = OP_CLEAR;
        win_nxt   = win_c;
        step_nxt  = WinW'(1);
        left_nxt  = kval;
        none_nxt  = (kval == '0);
        state_nxt = ST_SCORE;
      end
      ST_SCORE: begin
        sctl.op  = OP_SCORE;
        step_nxt = step_r + WinW'(1);
        if (step_r == win_r) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (spt[0].vld) begin
          sctl.op = OP_SHIFT;
          rop     = OP_INS;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          rop = OP_SHIFT;
          if (none_r || left_r == CW'(1)) begin
            state_nxt = ST_LOAD;
            count_nxt = '0;
            ovf_nxt   = 1'b0;
          end else begin
            left_nxt = left_r - CW'(1);
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
      keep_r  <= KeepReset;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      keep_r  <= keep_nxt;
    end
    win_r  <= win_nxt;
    step_r <= step_nxt;
    left_r <= left_nxt;
    none_r <= none_nxt;
  end

  // The two cell chains.
  for (genvar c = 0; c < N; c++) begin : g_cell
    dof_sort_cell u_sort (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (sctl),
      .pt_l    ((c == 0) ? nil_pt : spt[(c == 0) ? 0 : c-1]),
      .ins_l   ((c == 0) ? 1'b0 : sins[(c == 0) ? 0 : c-1]),
      .trr_l   ((c == 0) ? '0 : strr[(c == 0) ? 0 : c-1]),
      .trr_v_l ((c == 0) ? 1'b0 : strrv[(c == 0) ? 0 : c-1]),
      .pt_r    ((c == N-1) ? nil_pt : spt[(c == N-1) ? c : c+1]),
      .trl_r   ((c == N-1) ? '0 : strl[(c == N-1) ? c : c+1]),
      .trl_v_r ((c == N-1) ? 1'b0 : strlv[(c == N-1) ? c : c+1]),
      .pt      (spt[c]),
      .ins     (sins[c]),
      .trl     (strl[c]),
      .trl_v   (strlv[c]),
      .trr     (strr[c]),
      .trr_v   (strrv[c])
    );
    dof_rank_cell u_rank (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (rop),
      .y     (spt[0]),
      .pt_l  ((c == 0) ? nil_pt : rpt[(c == 0) ? 0 : c-1]),
      .ins_l ((c == 0) ? 1'b0 : rins[(c == 0) ? 0 : c-1]),
      .pt_r  ((c == N-1) ? nil_pt : rpt[(c == N-1) ? c : c+1]),
      .pt    (rpt[c]),
      .ins   (rins[c])
    );
  end

  // Results come straight from the registered head of the density chain.
  assign out_valid        = (state_r == ST_OUT);
  assign out_kept_value   = none_r ? '0 : rpt[0].val;
  assign out_final_result = none_r || (left_r == CW'(1));
  assign out_none_kept    = none_r;
  assign out_overflowed   = ovf_r;

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !none_r) |-> rpt[0].vld)
    else $error("density chain head empty while results remain");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SAMPLES))
    else $error("loaded count beyond capacity");
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_final_result) |=> (state_r == ST_LOAD && count_r == '0))
    else $error("run did not return to loading");

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the density outlier filter: a predictor scores each
// closed sample set and queues the kept values, which the monitor compares.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dof_pkg::*;

  localparam int Cap = 64;
  localparam int WatchLimit = 200000;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
  } sample_req_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            last;
    logic            empty;
    logic            ovf;
  } kept_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ValW-1:0] in_sample_value = '0;
  logic in_is_final = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ValW-1:0] out_kept_value;
  logic out_final_result;
  logic out_none_kept;
  logic out_overflowed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KeepW-1:0] cfg_keep_fraction = '0;

  always #10 clk = ~clk;

  density_outlier_filter_unit i_dut (.*);

  // Requests waiting to be driven, and kept values predicted but not yet seen.
  sample_req_t pending_samples[$];
  kept_t expected_kept[$];
  int fails = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int watch = 0;
  // High when the request on the input was accepted at the last rising edge.
  logic in_taken = 1'b0;

  // Predictor state: the open set and the current keep fraction.
  logic [ValW-1:0] set_vals[$];
  logic set_ovf = 1'b0;
  logic [KeepW-1:0] keep_frac = 17'd55706;

  // Returns 1 when point a is strictly denser than point b.
  function automatic bit more_dense(int ca, longint sa, int cb, longint sb);
    int ka;
    int kb;
    ka = (ca == 0) ? 0 : (sa == 0 ? 2 : 1);
    kb = (cb == 0) ? 0 : (sb == 0 ? 2 : 1);
    if (ka != kb) return ka > kb;
    if (ka != 1) return 0;
    return (longint'(ca) * sb) > (longint'(cb) * sa);
  endfunction

  // Scores the closed set and appends its kept values to the expectation queue.
  task automatic predict_set();
    logic [ValW-1:0] v[Cap];
    longint sums[Cap];
    int cnts[Cap];
    int ord[Cap];
    int n, w, lo, hi, x, q, k;
    logic [ValW-1:0] t;
    longint kk;
    n = set_vals.size();
    for (int i = 0; i < n; i++) v[i] = set_vals[i];
    for (int p = 1; p < n; p++) begin
      t = v[p];
      q = p;
      while (q > 0 && v[q-1] > t) begin
        v[q] = v[q-1];
        q--;
      end
      v[q] = t;
    end
    w = 0;
    while ((w + 1) * (w + 1) <= n) w++;
    if (w < 3) w = 3;
    if (w > 100) w = 100;
    for (int i = 0; i < n; i++) begin
      lo = (i > w) ? i - w : 0;
      hi = (i + w > n - 1) ? n - 1 : i + w;
      sums[i] = 0;
      cnts[i] = 0;
      for (int j = lo; j <= hi; j++) begin
        if (j != i) begin
          sums[i] += (v[j] >= v[i]) ? longint'(v[j] - v[i]) : longint'(v[i] - v[j]);
          cnts[i]++;
        end
      end
      sums[i] &= 64'hF_FFFF_FFFF;
      cnts[i] &= 31;
    end
    for (int i = 0; i < n; i++) ord[i] = i;
    for (int p = 1; p < n; p++) begin
      x = ord[p];
      q = p;
      while (q > 0 && more_dense(cnts[x], sums[x], cnts[ord[q-1]], sums[ord[q-1]])) begin
        ord[q] = ord[q-1];
        q--;
      end
      ord[q] = x;
    end
    kk = (longint'(keep_frac) * n + 32768) >>> 16;
    k = (kk > n) ? n : int'(kk);
    if (k == 0)
      expected_kept.insert(expected_kept.size(),
                           '{value: '0, last: 1'b1, empty: 1'b1, ovf: set_ovf});
    for (int i = 0; i < k; i++)
      expected_kept.insert(expected_kept.size(),
                           '{value: v[ord[i]], last: (i == k - 1), empty: 1'b0,
                             ovf: set_ovf});
    set_vals.delete();
    set_ovf = 1'b0;
  endtask

  // Driver: the valid stays high across back-to-back requests; one
  // nonblocking assignment per signal per falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_sample_value <= pending_samples[0].value;
          in_is_final <= pending_samples[0].last;
          void'(pending_samples.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Predictor hook and monitor, both at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        if (set_vals.size() < Cap) set_vals.insert(set_vals.size(), in_sample_value);
        else set_ovf = 1'b1;
        if (in_is_final) predict_set();
      end
      if (out_valid && !out_stall) begin
        if (expected_kept.size() == 0) begin
          $display("%0t: unexpected result value=%0d final=%0b none=%0b ovf=%0b", $time,
                   out_kept_value, out_final_result, out_none_kept, out_overflowed);
          fails++;
        end else begin
          if (expected_kept[0] !== {out_kept_value, out_final_result, out_none_kept,
                                    out_overflowed}) begin
            $display("%0t: expected value=%0d final=%0b none=%0b ovf=%0b", $time,
                     expected_kept[0].value, expected_kept[0].last, expected_kept[0].empty,
                     expected_kept[0].ovf);
            $display("%0t:   actual value=%0d final=%0b none=%0b ovf=%0b", $time,
                     out_kept_value, out_final_result, out_none_kept, out_overflowed);
            fails++;
          end
          void'(expected_kept.pop_front());
        end
      end
      // Watchdog counts cycles in which no request of any kind is accepted.
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        watch <= 0;
      else
        watch <= watch + 1;
      if (watch >= WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic add_sample(logic [ValW-1:0] value, bit last);
    pending_samples.insert(pending_samples.size(), '{value: value, last: last});
  endtask

  // A random set: mostly a clustered body with a few far outliers.
  task automatic add_random_set(int n);
    logic [ValW-1:0] centre;
    int spread;
    centre = $urandom;
    spread = 1 << $urandom_range(20);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) add_sample($urandom, i == n - 1);
      else add_sample(centre + $urandom_range(spread), i == n - 1);
    end
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && !in_valid);
    wait (expected_kept.size() == 0);
    repeat (200) @(posedge clk);
  endtask

  // Configuration writes happen only while the block is idle.
  task automatic write_keep(logic [KeepW-1:0] frac);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_keep_fraction <= frac;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    keep_frac = frac;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset fraction, single sample, duplicates, extremes.
    add_sample(32'd7, 1'b1);
    add_sample(32'd5, 1'b0);
    add_sample(32'd5, 1'b0);
    add_sample(32'd5, 1'b1);
    add_sample(32'hFFFF_FFFF, 1'b0);
    add_sample(32'h0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0);
    add_sample(32'h5555_AAAA, 1'b0);
    add_sample(32'hAAAA_5555, 1'b1);
    drain();

    // Fraction zero keeps nothing.
    write_keep(17'd0);
    add_sample(32'd1, 1'b0);
    add_sample(32'd9, 1'b1);
    drain();

    // Half rounds up: 3 samples at one half give two kept.
    write_keep(17'd32768);
    add_sample(32'd10, 1'b0);
    add_sample(32'd11, 1'b0);
    add_sample(32'd40, 1'b1);
    drain();

    // Fraction above one saturates; an overfull set drops samples,
    // including its final one.
    write_keep(17'h1FFFF);
    add_random_set(66);
    drain();

    // Random phases at varied fractions and idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 63 : 0;
      stall_pct = (ph == 2) ? 63 : (ph == 3 ? 25 : 0);
      if (ph == 3) send_idle_pct = 25;
      for (int s = 0; s < 2; s++) add_random_set($urandom_range(1, 10));
      drain();
      write_keep($urandom_range(65536));
    end
    send_idle_pct = 0;
    stall_pct = 0;
    write_keep(17'd55706);
    add_random_set(10);
    drain();

    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
